// File: src/mbc_pkg.sv
// Shared codes for the mapping block cache: operation codes, status codes
// and the unmapped marker. No dependencies.
`default_nettype none
package mbc_pkg;

  localparam int unsigned OP_W  = 4;
  localparam int unsigned LBA_W = 20;
  localparam int unsigned PBA_W = 32;
  localparam int unsigned BN_W  = 10;
  localparam int unsigned OFF_W = 10;
  localparam int unsigned ST_W  = 4;
  localparam int unsigned VIC_W = 10;
  localparam int unsigned SL_W  = 6;
  localparam int unsigned LIM_W = 7;

  localparam logic [OP_W-1:0] OP_UPDATE = 4'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 4'd1;
  localparam logic [OP_W-1:0] OP_EVICT  = 4'd2;
  localparam logic [OP_W-1:0] OP_PREP   = 4'd3;
  localparam logic [OP_W-1:0] OP_RDDONE = 4'd4;
  localparam logic [OP_W-1:0] OP_WRDONE = 4'd5;
  localparam logic [OP_W-1:0] OP_RELOC  = 4'd6;
  localparam logic [OP_W-1:0] OP_FILL   = 4'd7;
  localparam logic [OP_W-1:0] OP_RDWORD = 4'd8;

  localparam logic [ST_W-1:0] ST_HIT        = 4'd0;
  localparam logic [ST_W-1:0] ST_NEED_EVICT = 4'd1;
  localparam logic [ST_W-1:0] ST_NEED_READ  = 4'd2;
  localparam logic [ST_W-1:0] ST_FETCHING   = 4'd3;
  localparam logic [ST_W-1:0] ST_WAITING    = 4'd4;
  localparam logic [ST_W-1:0] ST_WRITE_BACK = 4'd5;
  localparam logic [ST_W-1:0] ST_REMOVED    = 4'd6;
  localparam logic [ST_W-1:0] ST_READ_OK    = 4'd7;
  localparam logic [ST_W-1:0] ST_READ_FAIL  = 4'd8;
  localparam logic [ST_W-1:0] ST_EVICT_OK   = 4'd9;
  localparam logic [ST_W-1:0] ST_EVICT_FAIL = 4'd10;
  localparam logic [ST_W-1:0] ST_RELOCATED  = 4'd11;
  localparam logic [ST_W-1:0] ST_RELOC_FAIL = 4'd12;
  localparam logic [ST_W-1:0] ST_DONE       = 4'd13;
  localparam logic [ST_W-1:0] ST_NO_VICTIM  = 4'd14;

  localparam logic [PBA_W-1:0] NONE_VAL = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// File: src/mbc_if.sv
// Request and response channel interfaces of the mapping block cache.
// Depends on mbc_pkg.
`default_nettype none
interface mbc_req_if import mbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [LBA_W-1:0] lba;
  logic [PBA_W-1:0] pba;
  logic [PBA_W-1:0] old_pba;
  logic [BN_W-1:0]  block_number;
  logic [OFF_W-1:0] word_offset;
  modport source (output valid, op, lba, pba, old_pba, block_number, word_offset,
                  input ready);
  modport sink (input valid, op, lba, pba, old_pba, block_number, word_offset,
                output ready);
endinterface

interface mbc_rsp_if import mbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [PBA_W-1:0] value;
  logic [VIC_W-1:0] victim_block;
  logic [SL_W-1:0]  slot;
  modport source (output valid, status, value, victim_block, slot, input ready);
  modport sink (input valid, status, value, victim_block, slot, output ready);
endinterface
`default_nettype wire

// File: src/mapping_block_cache_clock.sv
// Mapping block cache top level: slot words, block table and slot owners in
// RAMs, a sequencer for lookups, CLOCK eviction and slot management.
// Depends on mbc_pkg, mbc_if and mbc_ram.
//
// One request is handled at a time. After reset a clearing pass writes every
// slot word and block table entry, with no request taken. NUM_BLOCKS and
// ENTRIES are powers of two, so block and word numbers are bit fields of the
// request. A request passes through the accept state, a block table read
// state, a decide state and a state that loads the response register; a slot
// word read adds a state. A search for a free slot walks the free map one slot
// a cycle; reusing a slot clears its words. Evict walks the CLOCK hand one
// slot a cycle, and through an owner read and a check for a slot that has an
// owner and a clear clock bit, over at most 2*SLOTS slots. A finished response
// waits in its register while the next request is taken.
`default_nettype none
module mapping_block_cache_clock import mbc_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 1024,
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned ENTRIES    = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LIM_W-1:0] cfg_wdata_i,
  mbc_req_if.sink               req_i,
  mbc_rsp_if.source             rsp_o
);

  localparam int unsigned SW   = $clog2(SLOTS);
  localparam int unsigned BW   = $clog2(NUM_BLOCKS);
  localparam int unsigned EW   = $clog2(ENTRIES);
  localparam int unsigned SWD  = SLOTS * ENTRIES;
  localparam int unsigned SAW  = $clog2(SWD);
  localparam int unsigned FPW  = $clog2(SLOTS + 1);
  localparam int unsigned HCW  = $clog2(2 * SLOTS + 1);
  localparam int unsigned CLD  = (SWD > NUM_BLOCKS) ? SWD : NUM_BLOCKS;
  localparam int unsigned CLW  = $clog2(CLD);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_BTWT  = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_FS    = 4'd5;
  localparam logic [3:0] S_CLRS  = 4'd6;
  localparam logic [3:0] S_SWWT  = 4'd7;
  localparam logic [3:0] S_EVST  = 4'd8;
  localparam logic [3:0] S_EVOWN = 4'd9;
  localparam logic [3:0] S_EVCHK = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  typedef struct packed {
    logic          resident;
    logic [SW-1:0] slot;
    logic [31:0]   loc;
    logic          dirty;
    logic          fetching;
    logic          evicting;
  } bte_t;

  localparam int unsigned BTW = $bits(bte_t);

  function automatic logic [SAW-1:0] saddr(logic [SW-1:0] s, logic [EW-1:0] w);
    return SAW'(s * ENTRIES) + SAW'(w);
  endfunction

  logic [3:0]       state_q, state_d;
  logic [CLW-1:0]   clr_q, clr_d;
  logic [OP_W-1:0]  op_q;
  logic [PBA_W-1:0] pba_q, oldp_q;
  logic [BW-1:0]    blk_q, blk_d;
  logic [EW-1:0]    word_q, word_d;
  bte_t             ent_q, ent_d;
  logic [SW-1:0]    f_q, f_d;
  logic [EW-1:0]    cw_q, cw_d;
  logic             mclr_q, mclr_d;
  logic [SW-1:0]    hand_q, hand_d;
  logic [HCW-1:0]   hcnt_q, hcnt_d;
  logic [FPW-1:0]   fill_q, fill_d;
  logic [FPW-1:0]   evc_q, evc_d;
  logic [LIM_W-1:0] lim_q;
  logic [SLOTS-1:0] cbit_q, cbit_d;
  logic [SLOTS-1:0] oval_q, oval_d;
  logic [SLOTS-1:0] free_q, free_d;
  logic [ST_W-1:0]  r_st_q, r_st_d;
  logic [PBA_W-1:0] r_val_q, r_val_d;
  logic [VIC_W-1:0] r_vic_q, r_vic_d;
  logic [SL_W-1:0]  r_sl_q, r_sl_d;
  logic             ov_q, ov_d;
  logic             oload;
  logic [ST_W-1:0]  o_st_q;
  logic [PBA_W-1:0] o_val_q;
  logic [VIC_W-1:0] o_vic_q;
  logic [SL_W-1:0]  o_sl_q;

  logic             bt_we;
  logic [BW-1:0]    bt_wa, bt_ra;
  bte_t             bt_wd;
  logic [BTW-1:0]   bt_rd;
  logic             sw_we;
  logic [SAW-1:0]   sw_wa, sw_ra;
  logic [31:0]      sw_wd, sw_rd;
  logic             own_we;
  logic [SW-1:0]    own_wa, own_ra;
  logic [BW-1:0]    own_wd, own_rd;

  logic             accept;
  bte_t             e, nb;
  logic [SW-1:0]    h, s;
  logic [SL_W-1:0]  slot_of;

  mbc_ram #(.WIDTH(BTW), .DEPTH(NUM_BLOCKS)) u_bt_ram (
    .clk_i(clk_i), .we_i(bt_we), .waddr_i(bt_wa), .wdata_i(bt_wd),
    .raddr_i(bt_ra), .rdata_o(bt_rd)
  );

  mbc_ram #(.WIDTH(32), .DEPTH(SWD)) u_sw_ram (
    .clk_i(clk_i), .we_i(sw_we), .waddr_i(sw_wa), .wdata_i(sw_wd),
    .raddr_i(sw_ra), .rdata_o(sw_rd)
  );

  mbc_ram #(.WIDTH(BW), .DEPTH(SLOTS)) u_own_ram (
    .clk_i(clk_i), .we_i(own_we), .waddr_i(own_wa), .wdata_i(own_wd),
    .raddr_i(own_ra), .rdata_o(own_rd)
  );

  assign req_i.ready       = (state_q == S_IDLE);
  assign accept            = req_i.valid && req_i.ready;
  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = o_st_q;
  assign rsp_o.value       = o_val_q;
  assign rsp_o.victim_block = o_vic_q;
  assign rsp_o.slot        = o_sl_q;

  assign e       = bte_t'(bt_rd);
  assign h       = (hand_q == SW'(SLOTS - 1)) ? '0 : hand_q + 1'b1;
  assign own_ra  = h;
  assign bt_ra   = (state_q == S_EVOWN) ? own_rd : blk_q;
  assign sw_ra   = saddr(e.slot, word_q);
  assign slot_of = e.resident ? SL_W'(e.slot) : '0;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    blk_d    = blk_q;
    word_d   = word_q;
    ent_d    = ent_q;
    f_d      = f_q;
    cw_d     = cw_q;
    mclr_d   = mclr_q;
    hand_d   = hand_q;
    hcnt_d   = hcnt_q;
    fill_d   = fill_q;
    evc_d    = evc_q;
    cbit_d   = cbit_q;
    oval_d   = oval_q;
    free_d   = free_q;
    r_st_d   = r_st_q;
    r_val_d  = r_val_q;
    r_vic_d  = r_vic_q;
    r_sl_d   = r_sl_q;
    ov_d     = ov_q && !rsp_o.ready;
    oload    = 1'b0;
    bt_we    = 1'b0;
    bt_wa    = blk_q;
    bt_wd    = ent_q;
    sw_we    = 1'b0;
    sw_wa    = saddr(f_q, cw_q);
    sw_wd    = NONE_VAL;
    own_we   = 1'b0;
    own_wa   = f_q;
    own_wd   = blk_q;
    nb       = e;
    s        = e.slot;

    unique case (state_q)
      S_CLR: begin
        bt_we = (clr_q < NUM_BLOCKS);
        bt_wa = BW'(clr_q);
        bt_wd = '{resident: 1'b0, slot: '0, loc: NONE_VAL,
                  dirty: 1'b0, fetching: 1'b0, evicting: 1'b0};
        sw_we = (clr_q < SWD);
        sw_wa = SAW'(clr_q);
        clr_d = clr_q + 1'b1;
        if (clr_q == CLW'(CLD - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        r_val_d = NONE_VAL;
        r_vic_d = '0;
        r_sl_d  = '0;
        if (accept) begin
          if ((req_i.op == OP_UPDATE) || (req_i.op == OP_LOOKUP)) begin
            blk_d   = BW'(req_i.lba >> EW);
            word_d  = EW'(req_i.lba);
            state_d = S_BTWT;
          end else if ((req_i.op == OP_PREP) || (req_i.op == OP_RDDONE) ||
                       (req_i.op == OP_WRDONE) || (req_i.op == OP_RELOC) ||
                       (req_i.op == OP_FILL) || (req_i.op == OP_RDWORD)) begin
            blk_d   = BW'(req_i.block_number);
            word_d  = EW'(req_i.word_offset);
            state_d = S_BTWT;
          end else if (req_i.op == OP_EVICT) begin
            if (evc_q >= lim_q) begin
              r_st_d  = ST_WAITING;
              state_d = S_FIN;
            end else begin
              hcnt_d  = '0;
              state_d = S_EVST;
            end
          end else begin
            r_st_d  = ST_DONE;
            state_d = S_FIN;
          end
        end
      end
      S_BTWT: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        ent_d   = e;
        f_d     = '0;
        mclr_d  = 1'b0;
        state_d = S_FIN;
        unique case (op_q)
          OP_UPDATE: begin
            if (e.resident) begin
              cbit_d[s] = 1'b1;
              sw_we     = 1'b1;
              sw_wa     = saddr(s, word_q);
              sw_wd     = pba_q;
              nb.dirty  = 1'b1;
              nb.loc    = NONE_VAL;
              bt_we     = 1'b1;
              bt_wd     = nb;
              r_st_d    = ST_HIT;
              r_val_d   = e.loc;
              r_sl_d    = SL_W'(s);
            end else if (e.loc == NONE_VAL) begin
              if (fill_q < FPW'(SLOTS)) begin
                s           = SW'(fill_q);
                fill_d      = fill_q + 1'b1;
                free_d[s]   = 1'b0;
                oval_d[s]   = 1'b1;
                own_we      = 1'b1;
                own_wa      = s;
                sw_we       = 1'b1;
                sw_wa       = saddr(s, word_q);
                sw_wd       = pba_q;
                nb.resident = 1'b1;
                nb.slot     = s;
                nb.dirty    = 1'b1;
                bt_we       = 1'b1;
                bt_wd       = nb;
                r_st_d      = ST_HIT;
                r_sl_d      = SL_W'(s);
              end else begin
                mclr_d  = 1'b1;
                state_d = S_FS;
              end
            end else begin
              state_d = S_FS;
            end
          end
          OP_LOOKUP: begin
            if (e.resident) begin
              r_sl_d = SL_W'(s);
              if (e.fetching) begin
                r_st_d = ST_FETCHING;
              end else begin
                cbit_d[s] = 1'b1;
                r_st_d    = ST_HIT;
                state_d   = S_SWWT;
              end
            end else if (e.loc == NONE_VAL) begin
              r_st_d = ST_HIT;
            end else begin
              state_d = S_FS;
            end
          end
          OP_PREP: begin
            if (e.resident) begin
              r_sl_d = SL_W'(s);
              if (!e.fetching) begin
                r_st_d = ST_HIT;
              end else begin
                r_st_d  = ST_NEED_READ;
                r_val_d = e.loc;
              end
            end else begin
              state_d = S_FS;
            end
          end
          OP_RDDONE: begin
            r_st_d = ST_READ_FAIL;
            r_sl_d = slot_of;
            if (e.resident && e.fetching) begin
              nb.fetching = 1'b0;
              bt_we       = 1'b1;
              if (e.loc != pba_q) begin
                nb.resident = 1'b0;
                oval_d[s]   = 1'b0;
                free_d[s]   = 1'b1;
              end else begin
                cbit_d[s] = 1'b1;
                r_st_d    = ST_READ_OK;
              end
              bt_wd = nb;
            end
          end
          OP_WRDONE: begin
            r_st_d = ST_EVICT_FAIL;
            r_sl_d = slot_of;
            if (e.resident && e.evicting) begin
              nb.evicting = 1'b0;
              bt_we       = 1'b1;
              if (evc_q != '0) begin
                evc_d = evc_q - 1'b1;
              end
              if (!e.dirty) begin
                nb.resident = 1'b0;
                nb.loc      = pba_q;
                oval_d[s]   = 1'b0;
                free_d[s]   = 1'b1;
                cbit_d[s]   = 1'b1;
                r_st_d      = ST_EVICT_OK;
                r_val_d     = e.loc;
              end
              bt_wd = nb;
            end
          end
          OP_RELOC: begin
            r_sl_d = slot_of;
            if ((e.loc == oldp_q) && !e.dirty) begin
              nb.loc = pba_q;
              bt_we  = 1'b1;
              bt_wd  = nb;
              r_st_d = ST_RELOCATED;
            end else begin
              r_st_d = ST_RELOC_FAIL;
            end
          end
          OP_FILL: begin
            r_st_d = ST_DONE;
            r_sl_d = slot_of;
            sw_we  = e.resident;
            sw_wa  = saddr(s, word_q);
            sw_wd  = pba_q;
          end
          OP_RDWORD: begin
            r_st_d = ST_DONE;
            r_sl_d = slot_of;
            if (e.resident) begin
              state_d = S_SWWT;
            end
          end
          default: begin
            r_st_d = ST_DONE;
          end
        endcase
      end
      S_SWWT: begin
        r_val_d = sw_rd;
        state_d = S_FIN;
      end
      S_FS: begin
        nb = ent_q;
        if (free_q[f_q]) begin
          free_d[f_q] = 1'b0;
          oval_d[f_q] = 1'b1;
          own_we      = 1'b1;
          nb.resident = 1'b1;
          nb.slot     = f_q;
          bt_we       = 1'b1;
          r_sl_d      = SL_W'(f_q);
          if (mclr_q) begin
            nb.dirty = 1'b1;
            cw_d     = '0;
            r_st_d   = ST_HIT;
            state_d  = S_CLRS;
          end else begin
            nb.fetching = 1'b1;
            r_st_d      = ST_NEED_READ;
            r_val_d     = (op_q == OP_PREP) ? ent_q.loc : NONE_VAL;
            state_d     = S_FIN;
          end
          bt_wd = nb;
        end else if (f_q == SW'(SLOTS - 1)) begin
          r_st_d  = ST_NEED_EVICT;
          state_d = S_FIN;
        end else begin
          f_d = f_q + 1'b1;
        end
      end
      S_CLRS: begin
        sw_we = 1'b1;
        sw_wd = (cw_q == word_q) ? pba_q : NONE_VAL;
        cw_d  = cw_q + 1'b1;
        if (cw_q == EW'(ENTRIES - 1)) begin
          state_d = S_FIN;
        end
      end
      S_EVST: begin
        if (hcnt_q == HCW'(2 * SLOTS)) begin
          r_st_d  = ST_NO_VICTIM;
          state_d = S_FIN;
        end else begin
          hand_d = h;
          hcnt_d = hcnt_q + 1'b1;
          if (cbit_q[h]) begin
            cbit_d[h] = 1'b0;
          end else if (oval_q[h]) begin
            state_d = S_EVOWN;
          end
        end
      end
      S_EVOWN: begin
        blk_d   = own_rd;
        state_d = S_EVCHK;
      end
      S_EVCHK: begin
        if (e.evicting || e.fetching) begin
          state_d = S_EVST;
        end else begin
          bt_we   = 1'b1;
          r_vic_d = VIC_W'(blk_q);
          r_sl_d  = SL_W'(hand_q);
          state_d = S_FIN;
          if (!e.dirty) begin
            nb.resident = 1'b0;
            oval_d[s]   = 1'b0;
            free_d[s]   = 1'b1;
            r_st_d      = ST_REMOVED;
          end else begin
            nb.evicting = 1'b1;
            nb.dirty    = 1'b0;
            evc_d       = evc_q + 1'b1;
            r_st_d      = ST_WRITE_BACK;
          end
          bt_wd = nb;
        end
      end
      S_FIN: begin
        if (!ov_q || rsp_o.ready) begin
          oload   = 1'b1;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      hand_q   <= '0;
      hcnt_q   <= '0;
      fill_q   <= '0;
      evc_q    <= '0;
      lim_q    <= LIM_W'(8);
      cbit_q   <= '0;
      oval_q   <= '0;
      free_q   <= '0;
      ov_q     <= 1'b0;
      mclr_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      hand_q   <= hand_d;
      hcnt_q   <= hcnt_d;
      fill_q   <= fill_d;
      evc_q    <= evc_d;
      cbit_q   <= cbit_d;
      oval_q   <= oval_d;
      free_q   <= free_d;
      ov_q     <= ov_d;
      mclr_q   <= mclr_d;
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.op;
      pba_q  <= req_i.pba;
      oldp_q <= req_i.old_pba;
    end
    blk_q   <= blk_d;
    word_q  <= word_d;
    ent_q   <= ent_d;
    f_q     <= f_d;
    cw_q    <= cw_d;
    r_st_q  <= r_st_d;
    r_val_q <= r_val_d;
    r_vic_q <= r_vic_d;
    r_sl_q  <= r_sl_d;
    if (oload) begin
      o_st_q  <= r_st_q;
      o_val_q <= r_val_q;
      o_vic_q <= r_vic_q;
      o_sl_q  <= r_sl_q;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FPW'(SLOTS))
    else $error("fill pointer beyond slot count");

  a_evc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evc_q <= FPW'(SLOTS))
    else $error("evicting count beyond slot count");

  a_free_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q & oval_q) == '0)
    else $error("slot both free and owned");

  a_clr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |=> !ov_q)
    else $error("response during clearing pass");

endmodule
`default_nettype wire

// File: src/mbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: tb/sv/mbc_cache_checker.sv
// Response checker for the mapping block cache: watches the request,
// response and register ports, predicts each response and compares it.
// Depends on mbc_pkg and the mbc_req_if / mbc_rsp_if interfaces.
module mbc_cache_checker import mbc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LIM_W-1:0] cfg_wdata_i,
  mbc_req_if               req,
  mbc_rsp_if               rsp,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBLK = 1024;
  localparam int unsigned NSLOT = 64;
  localparam int unsigned NENT = 1024;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PBA_W-1:0] value;
    logic [VIC_W-1:0] victim;
    logic [SL_W-1:0]  slot;
  } cache_rsp_t;

  cache_rsp_t expected_rsps[$];

  logic [PBA_W-1:0] word_mem [NSLOT*NENT];
  bit               blk_res  [NBLK];
  int unsigned      blk_slot [NBLK];
  logic [PBA_W-1:0] blk_loc  [NBLK];
  bit               blk_dirty[NBLK];
  bit               blk_fetch[NBLK];
  bit               blk_evict[NBLK];
  bit               own_v    [NSLOT];
  int unsigned      own_blk  [NSLOT];
  bit               ref_bit  [NSLOT];
  bit               free_map [NSLOT];
  int unsigned      fill_ptr;
  int unsigned      hand;
  int unsigned      evict_cnt;
  logic [LIM_W-1:0] evict_limit;
  int               fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_rsps.size();

  function automatic int unsigned first_free_slot();
    for (int unsigned s = 0; s < NSLOT; s++) if (free_map[s]) return s;
    return NSLOT;
  endfunction

  function automatic void claim_slot(int unsigned b, int unsigned s);
    free_map[s] = 0;
    own_v[s] = 1;
    own_blk[s] = b;
    blk_res[b] = 1;
    blk_slot[b] = s;
  endfunction

  function automatic void drop_block(int unsigned b);
    int unsigned s;
    s = blk_slot[b] % NSLOT;
    blk_res[b] = 0;
    own_v[s] = 0;
    own_blk[s] = 0;
    free_map[s] = 1;
  endfunction

  function automatic bit begin_fetch(int unsigned b);
    int unsigned s;
    s = first_free_slot();
    if (s >= NSLOT) return 0;
    claim_slot(b, s);
    blk_fetch[b] = 1;
    return 1;
  endfunction

  function automatic int unsigned slot_held(int unsigned b);
    return blk_res[b] ? blk_slot[b] : 0;
  endfunction

  function automatic cache_rsp_t mk(logic [ST_W-1:0] st, logic [PBA_W-1:0] v,
                                    int unsigned vic, int unsigned sl);
    cache_rsp_t r;
    r.status = st;
    r.value = v;
    r.victim = vic[VIC_W-1:0];
    r.slot = sl[SL_W-1:0];
    return r;
  endfunction

  function automatic cache_rsp_t predict_cache_rsp(logic [OP_W-1:0] op,
      logic [LBA_W-1:0] lba, logic [PBA_W-1:0] pba, logic [PBA_W-1:0] oldp,
      logic [BN_W-1:0] bnum, logic [OFF_W-1:0] offs);
    int unsigned lb, lo, bn, off, s, v;
    logic [PBA_W-1:0] w;
    lb = lba[19:10];
    lo = lba[9:0];
    bn = bnum;
    off = offs;
    case (op)
      OP_UPDATE: begin
        if (blk_res[lb]) begin
          s = blk_slot[lb] % NSLOT;
          ref_bit[s] = 1;
          word_mem[s*NENT + lo] = pba;
          blk_dirty[lb] = 1;
          w = blk_loc[lb];
          blk_loc[lb] = NONE_VAL;
          return mk(ST_HIT, w, 0, s);
        end
        if (blk_loc[lb] == NONE_VAL) begin
          if (fill_ptr < NSLOT) begin
            s = fill_ptr;
            fill_ptr++;
            claim_slot(lb, s);
          end else begin
            s = first_free_slot();
            if (s >= NSLOT) return mk(ST_NEED_EVICT, NONE_VAL, 0, 0);
            claim_slot(lb, s);
            for (int unsigned i = 0; i < NENT; i++) word_mem[s*NENT + i] = NONE_VAL;
          end
          word_mem[s*NENT + lo] = pba;
          blk_dirty[lb] = 1;
          return mk(ST_HIT, NONE_VAL, 0, s);
        end
        if (begin_fetch(lb)) return mk(ST_NEED_READ, NONE_VAL, 0, blk_slot[lb]);
        return mk(ST_NEED_EVICT, NONE_VAL, 0, 0);
      end
      OP_LOOKUP: begin
        if (blk_res[lb]) begin
          s = blk_slot[lb] % NSLOT;
          if (blk_fetch[lb]) return mk(ST_FETCHING, NONE_VAL, 0, s);
          ref_bit[s] = 1;
          return mk(ST_HIT, word_mem[s*NENT + lo], 0, s);
        end
        if (blk_loc[lb] == NONE_VAL) return mk(ST_HIT, NONE_VAL, 0, 0);
        if (begin_fetch(lb)) return mk(ST_NEED_READ, NONE_VAL, 0, blk_slot[lb]);
        return mk(ST_NEED_EVICT, NONE_VAL, 0, 0);
      end
      OP_EVICT: begin
        if (evict_cnt >= evict_limit) return mk(ST_WAITING, NONE_VAL, 0, 0);
        for (int unsigned i = 0; i < 2*NSLOT; i++) begin
          hand = (hand + 1) % NSLOT;
          s = hand;
          if (ref_bit[s]) begin
            ref_bit[s] = 0;
            continue;
          end
          if (!own_v[s]) continue;
          v = own_blk[s] % NBLK;
          if (blk_evict[v] || blk_fetch[v]) continue;
          if (!blk_dirty[v]) begin
            drop_block(v);
            return mk(ST_REMOVED, NONE_VAL, v, s);
          end
          blk_evict[v] = 1;
          blk_dirty[v] = 0;
          evict_cnt++;
          return mk(ST_WRITE_BACK, NONE_VAL, v, s);
        end
        return mk(ST_NO_VICTIM, NONE_VAL, 0, 0);
      end
      OP_PREP: begin
        if (blk_res[bn]) begin
          if (!blk_fetch[bn]) return mk(ST_HIT, NONE_VAL, 0, blk_slot[bn]);
          return mk(ST_NEED_READ, blk_loc[bn], 0, blk_slot[bn]);
        end
        if (!begin_fetch(bn)) return mk(ST_NEED_EVICT, NONE_VAL, 0, 0);
        return mk(ST_NEED_READ, blk_loc[bn], 0, blk_slot[bn]);
      end
      OP_RDDONE: begin
        if (!blk_res[bn] || !blk_fetch[bn])
          return mk(ST_READ_FAIL, NONE_VAL, 0, slot_held(bn));
        s = blk_slot[bn] % NSLOT;
        blk_fetch[bn] = 0;
        if (blk_loc[bn] != pba) begin
          drop_block(bn);
          return mk(ST_READ_FAIL, NONE_VAL, 0, s);
        end
        ref_bit[s] = 1;
        return mk(ST_READ_OK, NONE_VAL, 0, s);
      end
      OP_WRDONE: begin
        if (!blk_res[bn] || !blk_evict[bn])
          return mk(ST_EVICT_FAIL, NONE_VAL, 0, slot_held(bn));
        s = blk_slot[bn] % NSLOT;
        blk_evict[bn] = 0;
        if (evict_cnt > 0) evict_cnt--;
        if (blk_dirty[bn]) return mk(ST_EVICT_FAIL, NONE_VAL, 0, s);
        drop_block(bn);
        ref_bit[s] = 1;
        w = blk_loc[bn];
        blk_loc[bn] = pba;
        return mk(ST_EVICT_OK, w, 0, s);
      end
      OP_RELOC: begin
        if (blk_loc[bn] == oldp && !blk_dirty[bn]) begin
          blk_loc[bn] = pba;
          return mk(ST_RELOCATED, NONE_VAL, 0, slot_held(bn));
        end
        return mk(ST_RELOC_FAIL, NONE_VAL, 0, slot_held(bn));
      end
      OP_FILL: begin
        if (blk_res[bn]) word_mem[(blk_slot[bn] % NSLOT)*NENT + off] = pba;
        return mk(ST_DONE, NONE_VAL, 0, slot_held(bn));
      end
      OP_RDWORD: begin
        w = blk_res[bn] ? word_mem[(blk_slot[bn] % NSLOT)*NENT + off] : NONE_VAL;
        return mk(ST_DONE, w, 0, slot_held(bn));
      end
      default: return mk(ST_DONE, NONE_VAL, 0, 0);
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_rsp_t exp_r;
    if (!rst_ni) begin
      foreach (word_mem[i]) word_mem[i] = NONE_VAL;
      for (int i = 0; i < NBLK; i++) begin
        blk_res[i] = 0;
        blk_slot[i] = 0;
        blk_loc[i] = NONE_VAL;
        blk_dirty[i] = 0;
        blk_fetch[i] = 0;
        blk_evict[i] = 0;
      end
      for (int i = 0; i < NSLOT; i++) begin
        own_v[i] = 0;
        own_blk[i] = 0;
        ref_bit[i] = 0;
        free_map[i] = 0;
      end
      fill_ptr = 0;
      hand = 0;
      evict_cnt = 0;
      evict_limit = 7'd8;
      fails = 0;
      expected_rsps.delete();
    end else begin
      if (cfg_we_i) evict_limit = cfg_wdata_i;
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          fails++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (rsp.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, rsp.status);
            fails++;
          end
          if (rsp.value !== exp_r.value) begin
            $error("value: expected %h, actual %h", exp_r.value, rsp.value);
            fails++;
          end
          if (rsp.victim_block !== exp_r.victim) begin
            $error("victim_block: expected %0d, actual %0d", exp_r.victim,
                   rsp.victim_block);
            fails++;
          end
          if (rsp.slot !== exp_r.slot) begin
            $error("slot: expected %0d, actual %0d", exp_r.slot, rsp.slot);
            fails++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_rsps.push_back(predict_cache_rsp(req.op, req.lba, req.pba,
                                                  req.old_pba, req.block_number,
                                                  req.word_offset));
    end
  end
endmodule

// File: tb/sv/mapping_block_cache_clock_tb.sv
// Top of the mapping block cache testbench: clock, reset, register writes,
// directed and random requests, watchdog and verdict.
// Depends on mbc_pkg, the channel interfaces, the block and mbc_cache_checker.
module mapping_block_cache_clock_tb import mbc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 200000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [LIM_W-1:0] cfg_wdata_i = '0;
  int               fail_count;
  int               pending;
  bit               calm = 1'b0;
  int               quiet_cycles = 0;
  logic [BN_W-1:0]  write_back_blocks[$];

  mbc_req_if req ();
  mbc_rsp_if rsp ();

  mapping_block_cache_clock dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_i(req), .rsp_o(rsp)
  );

  mbc_cache_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req), .rsp(rsp), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.op = OP_UPDATE;
    req.lba = '0;
    req.pba = '0;
    req.old_pba = '0;
    req.block_number = '0;
    req.word_offset = '0;
    rsp.ready = 1'b0;
  end

  always @(posedge clk_i)
    rsp.ready <= calm || ($urandom_range(0, 99) >= 15);

  always @(posedge clk_i)
    if (rsp.valid && rsp.ready && rsp.status == ST_WRITE_BACK)
      write_back_blocks.push_back(rsp.victim_block);

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("mapping_block_cache_clock_tb: errors");
      $finish;
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [LBA_W-1:0] lba,
                              logic [PBA_W-1:0] pba, logic [PBA_W-1:0] oldp,
                              logic [BN_W-1:0] bn, logic [OFF_W-1:0] off);
    req.valid <= 1'b1;
    req.op <= op;
    req.lba <= lba;
    req.pba <= pba;
    req.old_pba <= oldp;
    req.block_number <= bn;
    req.word_offset <= off;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    if (!calm && $urandom_range(0, 99) < 15) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] lim);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [PBA_W-1:0] pick_pba();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 3);
      3:       return NONE_VAL;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request;
    logic [OP_W-1:0]  op;
    logic [BN_W-1:0]  bn;
    logic [OFF_W-1:0] off;
    int               w;
    bn = ($urandom_range(0, 19) == 0) ? BN_W'($urandom_range(0, 1023))
                                      : BN_W'($urandom_range(0, 79));
    off = ($urandom_range(0, 7) == 0) ? OFF_W'($urandom_range(0, 1023))
                                      : OFF_W'($urandom_range(0, 15));
    w = $urandom_range(0, 99);
    if (w < 25)      op = OP_UPDATE;
    else if (w < 40) op = OP_LOOKUP;
    else if (w < 55) op = OP_EVICT;
    else if (w < 63) op = OP_PREP;
    else if (w < 71) op = OP_RDDONE;
    else if (w < 81) op = OP_WRDONE;
    else if (w < 87) op = OP_RELOC;
    else if (w < 93) op = OP_FILL;
    else if (w < 99) op = OP_RDWORD;
    else             op = OP_W'($urandom_range(9, 15));
    if (op == OP_WRDONE && write_back_blocks.size() != 0 && $urandom_range(0, 9) < 8)
      bn = write_back_blocks.pop_front();
    send_request(op, {bn, off}, pick_pba(), pick_pba(), bn, off);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n/3 && i < n/3 + 60);
      random_request();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_limit(7'd0);
    send_request(OP_EVICT, '0, '0, '0, '0, '0);
    send_request(OP_LOOKUP, '0, '0, '0, '0, '0);
    send_request(OP_RDWORD, '0, '0, '0, 10'd1023, 10'd1023);
    send_request(OP_FILL, '0, 32'h1234_5678, '0, 10'd5, 10'd5);
    send_request(OP_RDDONE, '0, '0, '0, 10'd5, '0);
    send_request(OP_WRDONE, '0, '0, '0, 10'd5, '0);
    send_request(4'd15, 20'hFFFFF, NONE_VAL, NONE_VAL, 10'd1023, 10'd1023);
    send_request(4'd9, '0, '0, '0, '0, '0);
    write_limit(7'd1);
    send_request(OP_UPDATE, 20'hFFFFF, NONE_VAL, '0, '0, '0);
    send_request(OP_UPDATE, 20'h00000, 32'h0, '0, '0, '0);
    send_request(OP_LOOKUP, 20'hFFFFF, '0, '0, '0, '0);
    send_request(OP_RELOC, '0, 32'd1, NONE_VAL, 10'd1023, '0);
    send_request(OP_FILL, '0, 32'hA5A5_5A5A, '0, 10'd1023, 10'd512);
    send_request(OP_RDWORD, '0, '0, '0, 10'd1023, 10'd512);
    send_request(OP_RELOC, '0, 32'd2, NONE_VAL, 10'd7, '0);
    send_request(OP_PREP, '0, '0, '0, 10'd7, '0);
    send_request(OP_LOOKUP, 20'h01C00, '0, '0, '0, '0);
    send_request(OP_RDDONE, '0, 32'd2, '0, 10'd7, '0);
    send_request(OP_EVICT, '0, '0, '0, '0, '0);
    send_request(OP_EVICT, '0, '0, '0, '0, '0);
    send_request(OP_WRDONE, '0, 32'd3, '0, 10'd0, '0);
    send_request(OP_WRDONE, '0, 32'd3, '0, 10'd1023, '0);

    random_phase(280);
    write_limit(7'd64);
    random_phase(280);
    drain();
    random_phase(20);
    write_limit(7'd127);
    random_phase(250);
    write_limit(7'($urandom_range(1, 64)));
    random_phase(300);

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("mapping_block_cache_clock_tb: clean");
    else $display("mapping_block_cache_clock_tb: errors");
    $finish;
  end
endmodule

// File: files.f
src/mbc_pkg.sv
src/mbc_if.sv
src/mbc_ram.sv
src/mapping_block_cache_clock.sv
tb/sv/mbc_cache_checker.sv
tb/sv/mapping_block_cache_clock_tb.sv
